// ===== rtl/xta_pkg.sv =====
// Package of the XVA trapezoid accumulator: item types, controller codes,
// datapath command and status structs and the saturating 64-bit add.
// It depends on nothing; every other file takes its names from it.
package xta_pkg;

    localparam int LimbW     = 32;
    localparam int NumLimbs  = 5;
    localparam int ProdW     = LimbW * NumLimbs;
    localparam int FactW     = 33;
    localparam int CarryW    = LimbW + 2;
    localparam int MulW      = 2 * LimbW + 2;
    localparam int LimbCntW  = $clog2(NumLimbs);
    localparam int ShProb    = 63;
    localparam int ShSpread  = 91;
    localparam int ShLoss    = 32;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 33;

    localparam logic [32:0] QOne = 33'h1_0000_0000;
    localparam logic signed [63:0] SumMax = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SumMin = 64'sh8000_0000_0000_0000;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_CPTY_REC  = 3'd0,
        CFG_OWN_REC   = 3'd1,
        CFG_FUND_SPR  = 3'd2,
        CFG_CAP_SPR   = 3'd3,
        CFG_MARG_SPR  = 3'd4,
        CFG_MARG_EN   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [47:0] pos_exposure;
        logic [47:0] neg_exposure;
        logic [47:0] margin_amount;
        logic [32:0] cpty_default_prob;
        logic [32:0] own_default_prob;
        logic [31:0] discount_factor;
        logic [31:0] year_fraction;
        logic        last_point;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] cva_value;
        logic signed [63:0] dva_value;
        logic signed [63:0] fva_value;
        logic signed [63:0] kva_value;
        logic signed [63:0] mva_value;
        logic signed [63:0] total_adjustment;
        logic               overflow;
    } t_out_item;

    typedef enum logic [2:0] {
        TERM_CREDIT,
        TERM_DEBIT,
        TERM_FUNDING,
        TERM_CAPITAL,
        TERM_MARGIN,
        TERM_CVA,
        TERM_DVA
    } t_term;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD,
        OP_MUL,
        OP_ROUND,
        OP_ACC,
        OP_COMMIT,
        OP_TOTAL,
        OP_EMIT
    } t_dp_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_ROUND,
        S_ACC,
        S_COMMIT,
        S_TOTAL,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_dp_op     op;
        t_term      term;
        logic [1:0] fidx;
        logic [1:0] tstep;
    } t_cmd;

    typedef struct packed {
        logic have_prev;
        logic last;
        logic margin_en;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic signed [63:0] sum;
        logic               ovf;
    } t_sat_res;

    function automatic logic [1:0] num_factors(input t_term term);
        logic [1:0] n;
        case (term)
            TERM_CREDIT, TERM_DEBIT: n = 2'd2;
            TERM_FUNDING, TERM_CAPITAL, TERM_MARGIN: n = 2'd3;
            default: n = 2'd1;
        endcase
        return n;
    endfunction

    function automatic t_sat_res sat_add64(input logic signed [63:0] a,
                                           input logic signed [63:0] b,
                                           input logic sub);
        logic [65:0] wa;
        logic [65:0] wb;
        logic [65:0] ws;
        t_sat_res    r;
        wa = {{2{a[63]}}, a};
        wb = {{2{b[63]}}, b};
        if (sub) begin
            wb = ~wb + 66'd1;
        end
        ws = wa + wb;
        r.ovf = (ws[65:63] != 3'b000) && (ws[65:63] != 3'b111);
        r.sum = r.ovf ? (ws[65] ? SumMin : SumMax) : ws[63:0];
        return r;
    endfunction

endpackage

// ===== rtl/xta_if.sv =====
// Channel interfaces of the XVA trapezoid accumulator: input items,
// results and configuration writes. They depend on xta_pkg.
interface xta_in_if;
    logic                valid;
    logic                ready;
    xta_pkg::t_in_item   data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface xta_out_if;
    logic                valid;
    logic                ready;
    xta_pkg::t_out_item  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface xta_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [xta_pkg::CfgIdxW-1:0]     index;
    logic [xta_pkg::CfgDataW-1:0]    data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/xta_ctrl.sv =====
// Sequencer of the XVA trapezoid accumulator. It steps the datapath through
// load, limb-serial multiply, round and accumulate for each term, and through
// commit, total and emit. It depends on xta_pkg.
module xta_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  xta_pkg::t_stat  i_stat,
    output xta_pkg::t_cmd   o_cmd
);

    xta_pkg::t_state                r_state, n_state;
    xta_pkg::t_term                 r_term, n_term;
    logic [1:0]                     r_fidx, n_fidx;
    logic [xta_pkg::LimbCntW-1:0]   r_limb, n_limb;
    logic [1:0]                     r_tstep, n_tstep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xta_pkg::S_IDLE;
            r_term  <= xta_pkg::TERM_CREDIT;
            r_fidx  <= 2'd0;
            r_limb  <= '0;
            r_tstep <= 2'd0;
        end else begin
            r_state <= n_state;
            r_term  <= n_term;
            r_fidx  <= n_fidx;
            r_limb  <= n_limb;
            r_tstep <= n_tstep;
        end
    end

    always_comb begin
        n_state = r_state;
        n_term  = r_term;
        n_fidx  = r_fidx;
        n_limb  = r_limb;
        n_tstep = r_tstep;
        case (r_state)
            xta_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.have_prev) begin
                        n_state = xta_pkg::S_LOAD;
                        n_term  = xta_pkg::TERM_CREDIT;
                    end else begin
                        n_state = xta_pkg::S_COMMIT;
                    end
                end
            end
            xta_pkg::S_LOAD: begin
                n_state = xta_pkg::S_MUL;
                n_fidx  = 2'd0;
                n_limb  = '0;
            end
            xta_pkg::S_MUL: begin
                if (r_limb == xta_pkg::LimbCntW'(xta_pkg::NumLimbs - 1)) begin
                    n_limb = '0;
                    if (r_fidx == xta_pkg::num_factors(r_term) - 2'd1) begin
                        n_state = xta_pkg::S_ROUND;
                    end else begin
                        n_fidx = r_fidx + 2'd1;
                    end
                end else begin
                    n_limb = r_limb + xta_pkg::LimbCntW'(1);
                end
            end
            xta_pkg::S_ROUND: begin
                n_state = xta_pkg::S_ACC;
            end
            xta_pkg::S_ACC: begin
                n_state = xta_pkg::S_LOAD;
                case (r_term)
                    xta_pkg::TERM_CREDIT:  n_term = xta_pkg::TERM_DEBIT;
                    xta_pkg::TERM_DEBIT:   n_term = xta_pkg::TERM_FUNDING;
                    xta_pkg::TERM_FUNDING: n_term = xta_pkg::TERM_CAPITAL;
                    xta_pkg::TERM_CAPITAL: begin
                        if (i_stat.margin_en) begin
                            n_term = xta_pkg::TERM_MARGIN;
                        end else begin
                            n_state = xta_pkg::S_COMMIT;
                        end
                    end
                    xta_pkg::TERM_MARGIN:  n_state = xta_pkg::S_COMMIT;
                    xta_pkg::TERM_CVA:     n_term = xta_pkg::TERM_DVA;
                    xta_pkg::TERM_DVA: begin
                        n_state = xta_pkg::S_TOTAL;
                        n_tstep = 2'd0;
                    end
                    default: n_state = xta_pkg::S_IDLE;
                endcase
            end
            xta_pkg::S_COMMIT: begin
                if (i_stat.last) begin
                    n_state = xta_pkg::S_LOAD;
                    n_term  = xta_pkg::TERM_CVA;
                end else begin
                    n_state = xta_pkg::S_IDLE;
                end
            end
            xta_pkg::S_TOTAL: begin
                if (r_tstep == 2'd3) begin
                    n_state = xta_pkg::S_EMIT;
                end else begin
                    n_tstep = r_tstep + 2'd1;
                end
            end
            xta_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = xta_pkg::S_IDLE;
                end
            end
            default: n_state = xta_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == xta_pkg::S_IDLE);
        o_cmd.term  = r_term;
        o_cmd.fidx  = r_fidx;
        o_cmd.tstep = r_tstep;
        case (r_state)
            xta_pkg::S_IDLE:   o_cmd.op = i_in_valid ? xta_pkg::OP_CAPTURE : xta_pkg::OP_NONE;
            xta_pkg::S_LOAD:   o_cmd.op = xta_pkg::OP_LOAD;
            xta_pkg::S_MUL:    o_cmd.op = xta_pkg::OP_MUL;
            xta_pkg::S_ROUND:  o_cmd.op = xta_pkg::OP_ROUND;
            xta_pkg::S_ACC:    o_cmd.op = xta_pkg::OP_ACC;
            xta_pkg::S_COMMIT: o_cmd.op = xta_pkg::OP_COMMIT;
            xta_pkg::S_TOTAL:  o_cmd.op = xta_pkg::OP_TOTAL;
            xta_pkg::S_EMIT:   o_cmd.op = i_stat.out_free ? xta_pkg::OP_EMIT : xta_pkg::OP_NONE;
            default:           o_cmd.op = xta_pkg::OP_NONE;
        endcase
    end

endmodule

// ===== rtl/xta_dpath.sv =====
// Datapath of the XVA trapezoid accumulator: configuration, previous point,
// accumulators, a 160-bit limb-serial product register and the result register.
// It depends on xta_pkg and the channel interfaces.
module xta_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xta_pkg::t_cmd     i_cmd,
    output xta_pkg::t_stat    o_stat,
    input  xta_pkg::t_in_item i_item,
    xta_cfg_if.sink           i_cfg,
    xta_out_if.source         o_res
);

    logic [32:0]                 r_cpty_rec;
    logic [32:0]                 r_own_rec;
    logic [31:0]                 r_fund_spr;
    logic [31:0]                 r_cap_spr;
    logic [31:0]                 r_marg_spr;
    logic                        r_margin_en;

    xta_pkg::t_in_item           r_item;
    logic [47:0]                 r_prev_pos;
    logic [47:0]                 r_prev_neg;
    logic [47:0]                 r_prev_mar;
    logic [32:0]                 r_prev_cp;
    logic [32:0]                 r_prev_op;
    logic                        r_have_prev;

    logic signed [63:0]          r_credit;
    logic signed [63:0]          r_debit;
    logic signed [63:0]          r_funding;
    logic signed [63:0]          r_capital;
    logic signed [63:0]          r_margin;
    logic signed [63:0]          r_cva;
    logic signed [63:0]          r_dva;
    logic signed [63:0]          r_tot;
    logic                        r_ovf;

    logic [xta_pkg::ProdW-1:0]   r_prod;
    logic [xta_pkg::CarryW-1:0]  r_carry;
    logic                        r_neg;

    logic                        r_out_valid;
    xta_pkg::t_out_item          r_out;

    logic [48:0]                 spos, sneg, smar;
    logic                        neg_c, neg_o, lneg_c, lneg_o;
    logic [32:0]                 dp_c, dp_o, fs_mag, cs_mag, ms_mag, loss_c, loss_o;
    logic [63:0]                 cred_mag, deb_mag;
    logic [xta_pkg::ProdW-1:0]   ld_val;
    logic                        ld_neg;
    logic [32:0]                 mul_x;
    logic [xta_pkg::MulW-1:0]    mul_v;
    logic [xta_pkg::ProdW-1:0]   rnd, shifted;
    logic                        over;
    logic [63:0]                 mag;
    logic signed [63:0]          term_val, acc_in, tot_a, tot_b, mva;
    logic                        tot_sub;
    xta_pkg::t_sat_res           acc_res, tot_res;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        spos = {1'b0, r_item.pos_exposure} + {1'b0, r_prev_pos};
        sneg = {1'b0, r_item.neg_exposure} + {1'b0, r_prev_neg};
        smar = {1'b0, r_item.margin_amount} + {1'b0, r_prev_mar};
        neg_c = r_item.cpty_default_prob < r_prev_cp;
        neg_o = r_item.own_default_prob < r_prev_op;
        dp_c = neg_c ? r_prev_cp - r_item.cpty_default_prob
                     : r_item.cpty_default_prob - r_prev_cp;
        dp_o = neg_o ? r_prev_op - r_item.own_default_prob
                     : r_item.own_default_prob - r_prev_op;
        fs_mag = r_fund_spr[31] ? xta_pkg::QOne - {1'b0, r_fund_spr} : {1'b0, r_fund_spr};
        cs_mag = r_cap_spr[31]  ? xta_pkg::QOne - {1'b0, r_cap_spr}  : {1'b0, r_cap_spr};
        ms_mag = r_marg_spr[31] ? xta_pkg::QOne - {1'b0, r_marg_spr} : {1'b0, r_marg_spr};
        lneg_c = r_cpty_rec > xta_pkg::QOne;
        lneg_o = r_own_rec > xta_pkg::QOne;
        loss_c = lneg_c ? r_cpty_rec - xta_pkg::QOne : xta_pkg::QOne - r_cpty_rec;
        loss_o = lneg_o ? r_own_rec - xta_pkg::QOne : xta_pkg::QOne - r_own_rec;
        cred_mag = r_credit[63] ? 64'd0 - 64'(r_credit) : 64'(r_credit);
        deb_mag  = r_debit[63]  ? 64'd0 - 64'(r_debit)  : 64'(r_debit);
    end

    always_comb begin
        case (i_cmd.term)
            xta_pkg::TERM_CREDIT: begin
                ld_val = xta_pkg::ProdW'(spos);
                ld_neg = neg_c;
                mul_x  = (i_cmd.fidx == 2'd0) ? dp_c : {1'b0, r_item.discount_factor};
            end
            xta_pkg::TERM_DEBIT: begin
                ld_val = xta_pkg::ProdW'(sneg);
                ld_neg = neg_o;
                mul_x  = (i_cmd.fidx == 2'd0) ? dp_o : {1'b0, r_item.discount_factor};
            end
            xta_pkg::TERM_FUNDING, xta_pkg::TERM_CAPITAL, xta_pkg::TERM_MARGIN: begin
                case (i_cmd.term)
                    xta_pkg::TERM_FUNDING: begin
                        ld_val = xta_pkg::ProdW'(spos);
                        ld_neg = r_fund_spr[31];
                        mul_x  = fs_mag;
                    end
                    xta_pkg::TERM_CAPITAL: begin
                        ld_val = xta_pkg::ProdW'(spos);
                        ld_neg = r_cap_spr[31];
                        mul_x  = cs_mag;
                    end
                    default: begin
                        ld_val = xta_pkg::ProdW'(smar);
                        ld_neg = r_marg_spr[31];
                        mul_x  = ms_mag;
                    end
                endcase
                if (i_cmd.fidx == 2'd1) begin
                    mul_x = {1'b0, r_item.year_fraction};
                end else if (i_cmd.fidx == 2'd2) begin
                    mul_x = {1'b0, r_item.discount_factor};
                end
            end
            xta_pkg::TERM_CVA: begin
                ld_val = xta_pkg::ProdW'(cred_mag);
                ld_neg = r_credit[63] ^ lneg_c;
                mul_x  = loss_c;
            end
            xta_pkg::TERM_DVA: begin
                ld_val = xta_pkg::ProdW'(deb_mag);
                ld_neg = r_debit[63] ^ lneg_o;
                mul_x  = loss_o;
            end
            default: begin
                ld_val = '0;
                ld_neg = 1'b0;
                mul_x  = '0;
            end
        endcase
    end

    assign mul_v = xta_pkg::MulW'(r_prod[xta_pkg::LimbW-1:0]) * xta_pkg::MulW'(mul_x)
                 + xta_pkg::MulW'(r_carry);

    always_comb begin
        case (i_cmd.term)
            xta_pkg::TERM_FUNDING, xta_pkg::TERM_CAPITAL, xta_pkg::TERM_MARGIN: begin
                rnd     = xta_pkg::ProdW'(1) << (xta_pkg::ShSpread - 1);
                shifted = r_prod >> xta_pkg::ShSpread;
            end
            xta_pkg::TERM_CVA, xta_pkg::TERM_DVA: begin
                rnd     = xta_pkg::ProdW'(1) << (xta_pkg::ShLoss - 1);
                shifted = r_prod >> xta_pkg::ShLoss;
            end
            default: begin
                rnd     = xta_pkg::ProdW'(1) << (xta_pkg::ShProb - 1);
                shifted = r_prod >> xta_pkg::ShProb;
            end
        endcase
        over     = |shifted[xta_pkg::ProdW-1:63];
        mag      = over ? 64'(xta_pkg::SumMax) : {1'b0, shifted[62:0]};
        term_val = r_neg ? $signed(64'd0 - mag) : $signed(mag);
        case (i_cmd.term)
            xta_pkg::TERM_CREDIT:  acc_in = r_credit;
            xta_pkg::TERM_DEBIT:   acc_in = r_debit;
            xta_pkg::TERM_FUNDING: acc_in = r_funding;
            xta_pkg::TERM_CAPITAL: acc_in = r_capital;
            default:               acc_in = r_margin;
        endcase
        acc_res = xta_pkg::sat_add64(acc_in, term_val, 1'b0);
    end

    always_comb begin
        mva     = r_margin_en ? r_margin : 64'sd0;
        tot_a   = r_tot;
        tot_sub = 1'b0;
        case (i_cmd.tstep)
            2'd0: begin
                tot_a   = r_cva;
                tot_b   = r_dva;
                tot_sub = 1'b1;
            end
            2'd1:    tot_b = r_funding;
            2'd2:    tot_b = r_capital;
            default: tot_b = mva;
        endcase
        tot_res = xta_pkg::sat_add64(tot_a, tot_b, tot_sub);
    end

    always_comb begin
        o_stat.have_prev = r_have_prev;
        o_stat.last      = r_item.last_point;
        o_stat.margin_en = r_margin_en;
        o_stat.out_free  = !r_out_valid || o_res.ready;
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpty_rec  <= '0;
            r_own_rec   <= '0;
            r_fund_spr  <= '0;
            r_cap_spr   <= '0;
            r_marg_spr  <= '0;
            r_margin_en <= 1'b0;
            r_have_prev <= 1'b0;
            r_credit    <= '0;
            r_debit     <= '0;
            r_funding   <= '0;
            r_capital   <= '0;
            r_margin    <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    xta_pkg::CFG_CPTY_REC: r_cpty_rec  <= i_cfg.data;
                    xta_pkg::CFG_OWN_REC:  r_own_rec   <= i_cfg.data;
                    xta_pkg::CFG_FUND_SPR: r_fund_spr  <= i_cfg.data[31:0];
                    xta_pkg::CFG_CAP_SPR:  r_cap_spr   <= i_cfg.data[31:0];
                    xta_pkg::CFG_MARG_SPR: r_marg_spr  <= i_cfg.data[31:0];
                    xta_pkg::CFG_MARG_EN:  r_margin_en <= i_cfg.data[0];
                    default: ;
                endcase
            end
            if (i_cmd.op == xta_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                xta_pkg::OP_CAPTURE: r_item <= i_item;
                xta_pkg::OP_LOAD: begin
                    r_prod  <= ld_val;
                    r_carry <= '0;
                    r_neg   <= ld_neg;
                end
                xta_pkg::OP_MUL: begin
                    r_prod  <= {mul_v[xta_pkg::LimbW-1:0],
                                r_prod[xta_pkg::ProdW-1:xta_pkg::LimbW]};
                    r_carry <= mul_v[xta_pkg::MulW-1:xta_pkg::LimbW];
                end
                xta_pkg::OP_ROUND: r_prod <= r_prod + rnd;
                xta_pkg::OP_ACC: begin
                    case (i_cmd.term)
                        xta_pkg::TERM_CREDIT:  r_credit  <= acc_res.sum;
                        xta_pkg::TERM_DEBIT:   r_debit   <= acc_res.sum;
                        xta_pkg::TERM_FUNDING: r_funding <= acc_res.sum;
                        xta_pkg::TERM_CAPITAL: r_capital <= acc_res.sum;
                        xta_pkg::TERM_MARGIN:  r_margin  <= acc_res.sum;
                        xta_pkg::TERM_CVA:     r_cva     <= term_val;
                        default:               r_dva     <= term_val;
                    endcase
                    if (i_cmd.term == xta_pkg::TERM_CVA || i_cmd.term == xta_pkg::TERM_DVA) begin
                        r_ovf <= r_ovf | over;
                    end else begin
                        r_ovf <= r_ovf | over | acc_res.ovf;
                    end
                end
                xta_pkg::OP_COMMIT: begin
                    r_prev_pos  <= r_item.pos_exposure;
                    r_prev_neg  <= r_item.neg_exposure;
                    r_prev_mar  <= r_item.margin_amount;
                    r_prev_cp   <= r_item.cpty_default_prob;
                    r_prev_op   <= r_item.own_default_prob;
                    r_have_prev <= 1'b1;
                end
                xta_pkg::OP_TOTAL: begin
                    r_tot <= tot_res.sum;
                    r_ovf <= r_ovf | tot_res.ovf;
                end
                xta_pkg::OP_EMIT: begin
                    r_out.cva_value        <= r_cva;
                    r_out.dva_value        <= r_dva;
                    r_out.fva_value        <= r_funding;
                    r_out.kva_value        <= r_capital;
                    r_out.mva_value        <= mva;
                    r_out.total_adjustment <= r_tot;
                    r_out.overflow         <= r_ovf;
                    r_credit               <= '0;
                    r_debit                <= '0;
                    r_funding              <= '0;
                    r_capital              <= '0;
                    r_margin               <= '0;
                    r_ovf                  <= 1'b0;
                    r_have_prev            <= 1'b0;
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/xva_trapezoid_accumulator.sv =====
// Top level of the XVA trapezoid accumulator. A grid's first point is only
// captured and committed; a later point runs each term through load, a multiply
// per factor on the shared 32x33 limb multiplier, round and accumulate. A last
// point adds the CVA, DVA and total steps before the result register loads.
// Points enter only when idle, even while a result waits. Reset is
// synchronous, active low, and clears configuration, accumulators, have_prev.
module xva_trapezoid_accumulator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xta_in_if.sink     i_in,
    xta_out_if.source  o_res,
    xta_cfg_if.sink    i_cfg
);

    xta_pkg::t_cmd  cmd;
    xta_pkg::t_stat stat;

    xta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    xta_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_item  (i_in.data),
        .i_cfg   (i_cfg),
        .o_res   (o_res)
    );

endmodule

// ===== rtl/xta_checker.sv =====
// Port checker of the XVA trapezoid accumulator and its bind statement.
// It depends on xta_pkg and watches only the top level's ports.
module xta_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input xta_pkg::t_out_item out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a request was taken");

    a_emit_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while the block was idle");

    a_total_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_data.overflow |->
        out_data.total_adjustment == out_data.cva_value - out_data.dva_value
            + out_data.fva_value + out_data.kva_value + out_data.mva_value)
        else $error("total differs from its parts without overflow");

endmodule

bind xva_trapezoid_accumulator xta_checker u_xta_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .out_valid (o_res.valid),
    .out_ready (o_res.ready),
    .out_data  (o_res.data)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Regression bench for the XVA trapezoid accumulator: directed grids, random grids
// under several register settings and idle patterns, checked against a bit-exact predictor.
// It depends on xta_pkg, the channel interfaces and xva_trapezoid_accumulator.
module testbench;

    localparam logic [191:0] MagMax = 192'h7FFF_FFFF_FFFF_FFFF;

    logic i_clk;
    logic i_rst_n;

    xta_in_if  in_ch ();
    xta_out_if res_ch ();
    xta_cfg_if cfg_ch ();

    xva_trapezoid_accumulator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    logic [32:0] cpty_rec, own_rec;
    logic [31:0] fund_spr, cap_spr, marg_spr;
    logic        marg_en;

    bit                 grid_open, grid_ovf;
    logic [47:0]        last_pos, last_neg, last_marg;
    logic [32:0]        last_cp, last_op;
    logic signed [63:0] credit_acc, debit_acc, fund_acc, cap_acc, marg_acc;

    xta_pkg::t_out_item adjust_queue[$];
    int        fail_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        recv_hold;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("xva_trapezoid_accumulator regression: fail");
        $finish;
    end

    function automatic logic signed [63:0] round_mag(input logic [191:0] p, input bit neg,
                                                     input int sh, inout bit ovf);
        logic [191:0]       m;
        logic signed [63:0] v;
        m = (p + (192'd1 << (sh - 1))) >> sh;
        if (m > MagMax) begin
            m = MagMax;
            ovf = 1'b1;
        end
        v = m[63:0];
        return neg ? -v : v;
    endfunction

    function automatic logic signed [63:0] add_clip(input logic signed [63:0] a,
                                                    input logic signed [63:0] b, inout bit ovf);
        logic signed [64:0] w;
        w = $signed({a[63], a}) + $signed({b[63], b});
        if (w > $signed({1'b0, xta_pkg::SumMax})) begin
            ovf = 1'b1;
            return xta_pkg::SumMax;
        end
        if (w < $signed({1'b1, xta_pkg::SumMin})) begin
            ovf = 1'b1;
            return xta_pkg::SumMin;
        end
        return w[63:0];
    endfunction

    function automatic logic signed [63:0] step_term(input logic [48:0] s, input logic [32:0] cur,
                                                     input logic [32:0] prv, input logic [31:0] df,
                                                     inout bit ovf);
        bit           neg;
        logic [191:0] p;
        neg = cur < prv;
        p = 192'(s) * 192'(neg ? prv - cur : cur - prv) * 192'(df);
        return round_mag(p, neg, xta_pkg::ShProb, ovf);
    endfunction

    function automatic logic signed [63:0] spread_term(input logic [48:0] s, input logic [31:0] spr,
                                                       input logic [31:0] tau,
                                                       input logic [31:0] df, inout bit ovf);
        bit           neg;
        logic [32:0]  m;
        logic [191:0] p;
        neg = spr[31];
        m = neg ? 33'h1_0000_0000 - {1'b0, spr} : {1'b0, spr};
        p = 192'(s) * 192'(m) * 192'(tau) * 192'(df);
        return round_mag(p, neg, xta_pkg::ShSpread, ovf);
    endfunction

    function automatic logic signed [63:0] loss_adjust(input logic signed [63:0] acc,
                                                       input logic [32:0] rec, inout bit ovf);
        bit           lneg, aneg;
        logic [63:0]  am;
        logic [32:0]  lm;
        lneg = rec > xta_pkg::QOne;
        aneg = acc < 0;
        am = aneg ? 64'd0 - acc : acc;
        lm = lneg ? rec - xta_pkg::QOne : xta_pkg::QOne - rec;
        return round_mag(192'(am) * 192'(lm), aneg != lneg, xta_pkg::ShLoss, ovf);
    endfunction

    task automatic predict_point(input xta_pkg::t_in_item it);
        bit                 ovf;
        logic [48:0]        spos;
        logic signed [63:0] cva, dva, mva, tot;
        xta_pkg::t_out_item r;
        ovf = grid_ovf;
        if (grid_open) begin
            spos = it.pos_exposure + last_pos;
            credit_acc = add_clip(credit_acc,
                step_term(spos, it.cpty_default_prob, last_cp, it.discount_factor, ovf), ovf);
            debit_acc = add_clip(debit_acc, step_term(it.neg_exposure + last_neg,
                it.own_default_prob, last_op, it.discount_factor, ovf), ovf);
            fund_acc = add_clip(fund_acc, spread_term(spos, fund_spr, it.year_fraction,
                it.discount_factor, ovf), ovf);
            cap_acc = add_clip(cap_acc, spread_term(spos, cap_spr, it.year_fraction,
                it.discount_factor, ovf), ovf);
            if (marg_en) begin
                marg_acc = add_clip(marg_acc, spread_term(it.margin_amount + last_marg,
                    marg_spr, it.year_fraction, it.discount_factor, ovf), ovf);
            end
        end
        grid_open = 1'b1;
        last_pos = it.pos_exposure;
        last_neg = it.neg_exposure;
        last_marg = it.margin_amount;
        last_cp = it.cpty_default_prob;
        last_op = it.own_default_prob;
        grid_ovf = ovf;
        if (it.last_point) begin
            cva = loss_adjust(credit_acc, cpty_rec, ovf);
            dva = loss_adjust(debit_acc, own_rec, ovf);
            mva = marg_en ? marg_acc : 64'sd0;
            if (dva == xta_pkg::SumMin) begin
                if (cva >= 0) begin
                    tot = xta_pkg::SumMax;
                    ovf = 1'b1;
                end else begin
                    tot = cva - dva;
                end
            end else begin
                tot = add_clip(cva, -dva, ovf);
            end
            tot = add_clip(tot, fund_acc, ovf);
            tot = add_clip(tot, cap_acc, ovf);
            tot = add_clip(tot, mva, ovf);
            r.cva_value = cva;
            r.dva_value = dva;
            r.fva_value = fund_acc;
            r.kva_value = cap_acc;
            r.mva_value = mva;
            r.total_adjustment = tot;
            r.overflow = ovf;
            adjust_queue.push_back(r);
            credit_acc = 0;
            debit_acc = 0;
            fund_acc = 0;
            cap_acc = 0;
            marg_acc = 0;
            grid_ovf = 1'b0;
            grid_open = 1'b0;
        end
    endtask

    task automatic send_point(input xta_pkg::t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data = it;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_point(it);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input xta_pkg::t_cfg_idx idx, input logic [32:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            xta_pkg::CFG_CPTY_REC: cpty_rec = val;
            xta_pkg::CFG_OWN_REC:  own_rec = val;
            xta_pkg::CFG_FUND_SPR: fund_spr = val[31:0];
            xta_pkg::CFG_CAP_SPR:  cap_spr = val[31:0];
            xta_pkg::CFG_MARG_SPR: marg_spr = val[31:0];
            default:               marg_en = val[0];
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic drain_results();
        in_ch.valid = 1'b0;
        wait (adjust_queue.size() == 0);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [32:0] cr, input logic [32:0] orr, input logic [31:0] fs,
                            input logic [31:0] cs, input logic [31:0] ms, input logic me);
        drain_results();
        write_reg(xta_pkg::CFG_CPTY_REC, cr);
        write_reg(xta_pkg::CFG_OWN_REC, orr);
        write_reg(xta_pkg::CFG_FUND_SPR, {1'b0, fs});
        write_reg(xta_pkg::CFG_CAP_SPR, {1'b0, cs});
        write_reg(xta_pkg::CFG_MARG_SPR, {1'b0, ms});
        write_reg(xta_pkg::CFG_MARG_EN, {32'd0, me});
    endtask

    function automatic logic [47:0] rand_amount();
        case ($urandom_range(0, 3))
            0:       return {$urandom, $urandom};
            1:       return 48'(int'($urandom_range(0, 1 << 24)));
            default: return {16'(int'($urandom_range(0, 2000))), $urandom};
        endcase
    endfunction

    function automatic logic [32:0] rand_prob(input logic [32:0] prv);
        logic [32:0] step;
        case ($urandom_range(0, 7))
            0:       return {1'(int'($urandom_range(0, 1))), $urandom};
            1:       return prv - 33'(int'($urandom_range(0, 1 << 20)));
            default: begin
                step = 33'(int'($urandom_range(0, 1 << 28)));
                return (prv + step > xta_pkg::QOne) ? prv : prv + step;
            end
        endcase
    endfunction

    function automatic xta_pkg::t_in_item rand_point(input xta_pkg::t_in_item prv,
                                                     input bit is_last);
        xta_pkg::t_in_item it;
        it.pos_exposure = rand_amount();
        it.neg_exposure = rand_amount();
        it.margin_amount = rand_amount();
        it.cpty_default_prob = rand_prob(prv.cpty_default_prob);
        it.own_default_prob = rand_prob(prv.own_default_prob);
        it.discount_factor = ($urandom_range(0, 4) == 0) ? $urandom
                             : 32'(int'($urandom_range(32'h3000_0000, 32'h4000_0000)));
        it.year_fraction = ($urandom_range(0, 4) == 0) ? $urandom
                           : 32'(int'($urandom_range(0, 32'h2000_0000)));
        it.last_point = is_last;
        return it;
    endfunction

    task automatic send_grid(input int len);
        xta_pkg::t_in_item it;
        it = '0;
        for (int k = 0; k < len; k++) begin
            it = rand_point(it, k == len - 1);
            send_point(it);
        end
    endtask

    task automatic random_grids(input int npoints);
        int sent;
        int len;
        xta_pkg::t_in_item it;
        sent = 0;
        while (sent < npoints) begin
            if ($urandom_range(0, 9) == 0) begin
                it = rand_point('0, $urandom_range(0, 1));
                send_point(it);
                sent++;
            end else begin
                len = $urandom_range(1, 6);
                send_grid(len);
                sent += len;
            end
        end
    endtask

    task automatic test_directed_points();
        xta_pkg::t_in_item it;
        set_regs(33'd0, 33'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        it = '0;
        it.last_point = 1'b1;
        send_point(it);
        it = '1;
        send_point(it);
        set_regs(xta_pkg::QOne, 33'h1_FFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 1'b1);
        it = '1;
        it.last_point = 1'b0;
        send_point(it);
        send_point(it);
        it.cpty_default_prob = '0;
        it.own_default_prob = '0;
        it.last_point = 1'b1;
        send_point(it);
        it = '0;
        it.pos_exposure = 48'h0001_0000_0000;
        it.neg_exposure = 48'h0000_8000_0000;
        it.margin_amount = 48'h0002_0000_0000;
        it.cpty_default_prob = 33'h0_1000_0000;
        it.own_default_prob = 33'h0_2000_0000;
        it.discount_factor = 32'h4000_0000;
        it.year_fraction = 32'h1000_0000;
        send_point(it);
        it.cpty_default_prob = 33'h0_0800_0000;
        it.own_default_prob = 33'h1_4000_0000;
        send_point(it);
        it.last_point = 1'b1;
        send_point(it);
        set_regs(33'h0_6666_6666, 33'h0_4000_0000, 32'h0010_0000, 32'hFFF0_0000,
                 32'h0001_0000, 1'b0);
        send_grid(4);
        send_grid(1);
    endtask

    task automatic test_random_phase(input int sip, input int rip, input int npoints);
        set_regs({1'(int'($urandom_range(0, 1))), $urandom} & 33'h1_3FFF_FFFF,
                 33'(int'($urandom_range(0, 32'h7000_0000))), $urandom, $urandom, $urandom,
                 1'($urandom_range(0, 1)));
        send_idle_pct = sip;
        recv_idle_pct = rip;
        random_grids(npoints);
    endtask

    task automatic test_backpressure();
        xta_pkg::t_in_item it;
        drain_results();
        recv_hold = 3000;
        for (int k = 0; k < 12; k++) begin
            it = rand_point('0, 1'b1);
            send_point(it);
        end
    endtask

    task automatic test_drain_pause();
        send_grid(3);
        drain_results();
        send_grid(5);
    endtask

    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            res_ch.ready <= 1'b0;
            recv_hold <= recv_hold - 1;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        xta_pkg::t_out_item exp_r;
        xta_pkg::t_out_item got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            if (adjust_queue.size() == 0) begin
                $error("unexpected adjustment result");
                fail_count++;
            end else begin
                exp_r = adjust_queue.pop_front();
                if (got.cva_value !== exp_r.cva_value) begin
                    $error("cva_value: expected %0d, got %0d", exp_r.cva_value, got.cva_value);
                    fail_count++;
                end
                if (got.dva_value !== exp_r.dva_value) begin
                    $error("dva_value: expected %0d, got %0d", exp_r.dva_value, got.dva_value);
                    fail_count++;
                end
                if (got.fva_value !== exp_r.fva_value) begin
                    $error("fva_value: expected %0d, got %0d", exp_r.fva_value, got.fva_value);
                    fail_count++;
                end
                if (got.kva_value !== exp_r.kva_value) begin
                    $error("kva_value: expected %0d, got %0d", exp_r.kva_value, got.kva_value);
                    fail_count++;
                end
                if (got.mva_value !== exp_r.mva_value) begin
                    $error("mva_value: expected %0d, got %0d", exp_r.mva_value, got.mva_value);
                    fail_count++;
                end
                if (got.total_adjustment !== exp_r.total_adjustment) begin
                    $error("total_adjustment: expected %0d, got %0d",
                           exp_r.total_adjustment, got.total_adjustment);
                    fail_count++;
                end
                if (got.overflow !== exp_r.overflow) begin
                    $error("overflow: expected %0b, got %0b", exp_r.overflow, got.overflow);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        fail_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 0;
        res_ch.ready = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = xta_pkg::CFG_CPTY_REC;
        cfg_ch.data = '0;
        cpty_rec = '0;
        own_rec = '0;
        fund_spr = '0;
        cap_spr = '0;
        marg_spr = '0;
        marg_en = 1'b0;
        grid_open = 1'b0;
        grid_ovf = 1'b0;
        last_pos = '0;
        last_neg = '0;
        last_marg = '0;
        last_cp = '0;
        last_op = '0;
        credit_acc = 0;
        debit_acc = 0;
        fund_acc = 0;
        cap_acc = 0;
        marg_acc = 0;
        i_rst_n = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_points();
        test_random_phase(17, 48, 280);
        test_random_phase(17, 48, 250);
        test_backpressure();
        test_random_phase(48, 17, 280);
        test_random_phase(48, 17, 250);
        test_drain_pause();
        test_random_phase(0, 0, 250);
        test_random_phase(0, 0, 250);
        drain_results();
        if (fail_count == 0) begin
            $display("xva_trapezoid_accumulator regression: pass");
        end else begin
            $display("xva_trapezoid_accumulator regression: fail");
        end
        $finish;
    end

endmodule
